/* src/rsp_pkg.sv */
// shared types and constants of the ray / sphere first-hit picker
// no dependencies; used by rsp_mac and ray_sphere_first_hit_picker
package rsp_pkg;

	// default parameter values
	localparam int DEF_MAX_SPHERES = 256;
	localparam int DEF_COORD_BITS  = 16;

	// fixed field widths
	localparam int COUNT_W    = 9;
	localparam int RADIUS_W   = 15;
	localparam int SLOT_W     = 8;
	localparam int INDEX_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;
	localparam int STEP_W     = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STAR_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STAR_RADIUS = 1'b1;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// sequencer step counts: issue steps, then one drain step, then capture
	localparam int RAD_TERMS = 1;
	localparam int DOT_TERMS = 3;
	localparam int CMP_TERMS = 8;
	localparam logic [STEP_W-1:0] RAD_CAP = STEP_W'(RAD_TERMS + 1);
	localparam logic [STEP_W-1:0] DOT_CAP = STEP_W'(DOT_TERMS + 1);
	localparam logic [STEP_W-1:0] CMP_CAP = STEP_W'(CMP_TERMS + 1);

	typedef enum logic [1:0] {
		SH_NONE,
		SH_ONE,
		SH_TWO
	} shift_t;

	// one request to the shared multiply-accumulate unit
	typedef struct packed {
		logic   issue;
		logic   clear;
		logic   sub;
		shift_t shift;
	} mac_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RADIUS,
		ST_DOT_DD,
		ST_FETCH,
		ST_WDIFF,
		ST_DOT_DW,
		ST_DOT_WW,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

/* src/ray_sphere_first_hit_picker.sv */
// ray / sphere first-hit picker: handshakes, config registers and scan sequencer
// depends on rsp_pkg, rsp_table and rsp_mac
//
// Usage: a load word (command = load) writes one sphere centre into the table
// at slot; slots at or above MAX_SPHERES are dropped. A query word gives a ray
// origin and direction; the block scans entries 0 to star_count-1 (saturated to
// MAX_SPHERES) and returns one word: hit and the lowest index whose sphere of
// radius star_radius meets the ray line. A miss returns hit = 0, hit_index = 0.
// Loads return nothing. Config is written through cfg_wr_en; the user must write
// it only while idle, as the block itself does not enforce this. in_ready is
// high only while the sequencer is idle. Every product of a query goes through
// the single shared multiplier: 3 + 3 products per scanned entry, plus 8 more
// when the compare step runs, besides the table read and drains.
// The result sits in an output register; while out_ready is low the word waits
// there. Loads and the next query are still taken; that query holds in its done
// state until the register frees, and only then is another word accepted.
// Reset clears star_count to 0, star_radius to 256 (1.0), and all handshake
// state; the table contents are undefined until written.
module ray_sphere_first_hit_picker #(
	parameter int MAX_SPHERES = rsp_pkg::DEF_MAX_SPHERES,
	parameter int COORD_BITS  = rsp_pkg::DEF_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             command,
	input  logic [rsp_pkg::SLOT_W-1:0]       slot,
	input  logic signed [COORD_BITS-1:0]     pos_x,
	input  logic signed [COORD_BITS-1:0]     pos_y,
	input  logic signed [COORD_BITS-1:0]     pos_z,
	input  logic signed [COORD_BITS-1:0]     dir_x,
	input  logic signed [COORD_BITS-1:0]     dir_y,
	input  logic signed [COORD_BITS-1:0]     dir_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic [rsp_pkg::INDEX_W-1:0]      hit_index,
	input  logic                             cfg_wr_en,
	input  logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int CW     = COORD_BITS;
	localparam int K      = CW + 1;
	localparam int MW     = (CW + 2 > 16) ? CW + 2 : 16;
	localparam int AW     = 4 * CW + 4;
	localparam int ADDR_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int IDX_W  = $clog2(MAX_SPHERES + 1);
	localparam int R2_W   = 2 * rsp_pkg::RADIUS_W;

	rsp_pkg::state_t state_q, state_d;
	logic [rsp_pkg::STEP_W-1:0] step_q;

	logic [rsp_pkg::COUNT_W-1:0]  star_count_q;
	logic [rsp_pkg::RADIUS_W-1:0] star_radius_q;

	logic signed [CW-1:0] org_x_q, org_y_q, org_z_q;
	logic signed [CW-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic signed [CW:0]   w_x_q, w_y_q, w_z_q;
	logic [R2_W-1:0]      r2_q;
	logic [2*K-1:0]       a_q, p_mag_q, cc_q;
	logic [IDX_W-1:0]     idx_q, lim;
	logic                 res_hit_q;

	logic                        out_valid_q, hit_q;
	logic [rsp_pkg::INDEX_W-1:0] hit_index_q;

	logic                 accept, out_free, slot_ok;
	logic [3*CW-1:0]      rd_data;
	logic signed [CW-1:0] c_x, c_y, c_z;

	rsp_pkg::mac_op_t     mop;
	logic signed [MW-1:0] opa, opb;
	logic signed [AW-1:0] acc, acc_abs, cc_full;
	logic                 cc_hit, cmp_hit;

	assign in_ready = (state_q == rsp_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign slot_ok  = int'(slot) < MAX_SPHERES;

	assign lim = (int'(star_count_q) > MAX_SPHERES) ? IDX_W'(MAX_SPHERES)
		: IDX_W'(star_count_q);

	rsp_table #(
		.DEPTH (MAX_SPHERES),
		.ADDR_W(ADDR_W),
		.DATA_W(3 * CW)
	) u_table (
		.clk    (clk),
		.wr_en  (accept && command == rsp_pkg::CMD_LOAD && slot_ok),
		.wr_addr(ADDR_W'(slot)),
		.wr_data({pos_z, pos_y, pos_x}),
		.rd_addr(idx_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	assign c_x = $signed(rd_data[CW-1:0]);
	assign c_y = $signed(rd_data[2*CW-1:CW]);
	assign c_z = $signed(rd_data[3*CW-1:2*CW]);

	rsp_mac #(
		.MW(MW),
		.AW(AW),
		.K (K)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (mop),
		.opa   (opa),
		.opb   (opb),
		.acc   (acc)
	);

	assign acc_abs = acc[AW-1] ? -acc : acc;
	assign cc_full = acc - $signed(AW'(r2_q));
	// origin inside or on the sphere surface: a hit, and the compare step is skipped
	assign cc_hit  = cc_full[AW-1] || (cc_full == '0);
	assign cmp_hit = !acc[AW-1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsp_pkg::ST_IDLE: begin
				if (accept && command == rsp_pkg::CMD_QUERY) begin
					state_d = rsp_pkg::ST_RADIUS;
				end
			end
			rsp_pkg::ST_RADIUS: begin
				if (step_q == rsp_pkg::RAD_CAP) begin
					state_d = rsp_pkg::ST_DOT_DD;
				end
			end
			rsp_pkg::ST_DOT_DD: begin
				if (step_q == rsp_pkg::DOT_CAP) begin
					state_d = rsp_pkg::ST_FETCH;
				end
			end
			rsp_pkg::ST_FETCH: begin
				state_d = (idx_q == lim) ? rsp_pkg::ST_DONE : rsp_pkg::ST_WDIFF;
			end
			rsp_pkg::ST_WDIFF: state_d = rsp_pkg::ST_DOT_DW;
			rsp_pkg::ST_DOT_DW: begin
				if (step_q == rsp_pkg::DOT_CAP) begin
					state_d = rsp_pkg::ST_DOT_WW;
				end
			end
			rsp_pkg::ST_DOT_WW: begin
				if (step_q == rsp_pkg::DOT_CAP) begin
					state_d = cc_hit ? rsp_pkg::ST_DONE : rsp_pkg::ST_CMP;
				end
			end
			rsp_pkg::ST_CMP: begin
				if (step_q == rsp_pkg::CMP_CAP) begin
					state_d = cmp_hit ? rsp_pkg::ST_DONE : rsp_pkg::ST_FETCH;
				end
			end
			rsp_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rsp_pkg::ST_IDLE;
				end
			end
			default: state_d = rsp_pkg::ST_IDLE;
		endcase
	end

	// multiplier requests
	always_comb begin
		mop       = '0;
		mop.shift = rsp_pkg::SH_NONE;
		opa       = '0;
		opb       = '0;
		unique case (state_q)
			rsp_pkg::ST_RADIUS: begin
				if (step_q < rsp_pkg::STEP_W'(rsp_pkg::RAD_TERMS)) begin
					mop.issue = 1'b1;
					mop.clear = 1'b1;
					opa       = $signed(MW'(star_radius_q));
					opb       = $signed(MW'(star_radius_q));
				end
			end
			rsp_pkg::ST_DOT_DD, rsp_pkg::ST_DOT_DW, rsp_pkg::ST_DOT_WW: begin
				if (step_q < rsp_pkg::STEP_W'(rsp_pkg::DOT_TERMS)) begin
					mop.issue = 1'b1;
					mop.clear = (step_q == '0);
					unique case (state_q)
						rsp_pkg::ST_DOT_DD: begin
							opa = (step_q == 0) ? MW'(dir_x_q)
								: (step_q == 1) ? MW'(dir_y_q) : MW'(dir_z_q);
							opb = opa;
						end
						rsp_pkg::ST_DOT_DW: begin
							opa = (step_q == 0) ? MW'(dir_x_q)
								: (step_q == 1) ? MW'(dir_y_q) : MW'(dir_z_q);
							opb = (step_q == 0) ? MW'(w_x_q)
								: (step_q == 1) ? MW'(w_y_q) : MW'(w_z_q);
						end
						default: begin
							opa = (step_q == 0) ? MW'(w_x_q)
								: (step_q == 1) ? MW'(w_y_q) : MW'(w_z_q);
							opb = opa;
						end
					endcase
				end
			end
			rsp_pkg::ST_CMP: begin
				// p^2 from magnitude limbs, minus a*cc from limbs
				if (step_q < rsp_pkg::STEP_W'(rsp_pkg::CMP_TERMS)) begin
					mop.issue = 1'b1;
					mop.clear = (step_q == '0);
					mop.sub   = step_q[2];
					unique case (step_q[1:0])
						2'd0:    mop.shift = rsp_pkg::SH_TWO;
						2'd3:    mop.shift = rsp_pkg::SH_NONE;
						default: mop.shift = rsp_pkg::SH_ONE;
					endcase
					if (step_q[2]) begin
						opa = $signed(MW'(step_q[1] ? a_q[K-1:0] : a_q[2*K-1:K]));
						opb = $signed(MW'(step_q[0] ? cc_q[K-1:0] : cc_q[2*K-1:K]));
					end else begin
						opa = $signed(MW'(step_q[1] ? p_mag_q[K-1:0] : p_mag_q[2*K-1:K]));
						opb = $signed(MW'(step_q[0] ? p_mag_q[K-1:0] : p_mag_q[2*K-1:K]));
					end
				end
			end
			default: begin
				mop.issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rsp_pkg::ST_IDLE;
			step_q        <= '0;
			star_count_q  <= '0;
			star_radius_q <= rsp_pkg::RADIUS_W'(256);
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					rsp_pkg::REG_STAR_COUNT:  star_count_q  <= cfg_wdata[rsp_pkg::COUNT_W-1:0];
					rsp_pkg::REG_STAR_RADIUS: star_radius_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == rsp_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			org_x_q   <= pos_x;
			org_y_q   <= pos_y;
			org_z_q   <= pos_z;
			dir_x_q   <= dir_x;
			dir_y_q   <= dir_y;
			dir_z_q   <= dir_z;
			idx_q     <= '0;
			res_hit_q <= 1'b0;
		end
		if (state_q == rsp_pkg::ST_RADIUS && step_q == rsp_pkg::RAD_CAP) begin
			r2_q <= acc[R2_W-1:0];
		end
		if (state_q == rsp_pkg::ST_DOT_DD && step_q == rsp_pkg::DOT_CAP) begin
			a_q <= acc[2*K-1:0];
		end
		if (state_q == rsp_pkg::ST_WDIFF) begin
			w_x_q <= (CW + 1)'(org_x_q) - (CW + 1)'(c_x);
			w_y_q <= (CW + 1)'(org_y_q) - (CW + 1)'(c_y);
			w_z_q <= (CW + 1)'(org_z_q) - (CW + 1)'(c_z);
		end
		if (state_q == rsp_pkg::ST_DOT_DW && step_q == rsp_pkg::DOT_CAP) begin
			p_mag_q <= acc_abs[2*K-1:0];
		end
		if (state_q == rsp_pkg::ST_DOT_WW && step_q == rsp_pkg::DOT_CAP) begin
			cc_q <= cc_full[2*K-1:0];
			if (cc_hit) begin
				res_hit_q <= 1'b1;
			end
		end
		if (state_q == rsp_pkg::ST_CMP && step_q == rsp_pkg::CMP_CAP) begin
			if (cmp_hit) begin
				res_hit_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (state_q == rsp_pkg::ST_DONE && out_free) begin
			hit_q       <= res_hit_q;
			hit_index_q <= res_hit_q ? rsp_pkg::INDEX_W'(idx_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_index = hit_index_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsp_pkg::ST_FETCH) |-> (idx_q <= lim))
		else $error("scan index past entry limit");

	a_hit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsp_pkg::ST_DONE && res_hit_q) |-> (idx_q < lim))
		else $error("hit reported on an entry outside the scan");

	a_miss_full_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsp_pkg::ST_DONE && !res_hit_q) |-> (idx_q == lim))
		else $error("miss reported before the scan ended");

	a_word_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == rsp_pkg::ST_DONE))
		else $error("result word raised outside the done state");

endmodule

/* src/rsp_table.sv */
// centre table: one write port, one registered read port
// no package dependencies; instantiated by ray_sphere_first_hit_picker
module rsp_table #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/rsp_mac.sv */
// shared signed multiplier with a registered product and a shifting accumulator
// depends on rsp_pkg (mac_op_t, shift_t)
module rsp_mac #(
	parameter int MW = 18,
	parameter int AW = 68,
	parameter int K  = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsp_pkg::mac_op_t     op,
	input  logic signed [MW-1:0] opa,
	input  logic signed [MW-1:0] opb,
	output logic signed [AW-1:0] acc
);

	rsp_pkg::mac_op_t       op_s1;
	logic signed [2*MW-1:0] prod_s1;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   ext;
	logic signed [AW-1:0]   term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end

	// limb products land at weight 1, 2^K or 2^2K
	always_comb begin
		ext = AW'(prod_s1);
		unique case (op_s1.shift)
			rsp_pkg::SH_NONE: term = ext;
			rsp_pkg::SH_ONE:  term = ext << K;
			rsp_pkg::SH_TWO:  term = ext << (2 * K);
			default:          term = ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op_s1.issue) begin
			priority if (op_s1.clear) begin
				acc_q <= op_s1.sub ? -term : term;
			end else if (op_s1.sub) begin
				acc_q <= acc_q - term;
			end else begin
				acc_q <= acc_q + term;
			end
		end
	end

	assign acc = acc_q;

endmodule

/* tb/tb.sv */
// self-checking testbench for ray_sphere_first_hit_picker: loads sphere centres, fires ray
// queries and checks each hit word against an exact wide-integer line/sphere predictor
// depends on rsp_pkg and the picker rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS      = rsp_pkg::DEF_MAX_SPHERES;
	localparam int CW             = rsp_pkg::DEF_COORD_BITS;
	localparam int WORD_TARGET    = 1550;
	localparam int DRAIN_CYCLES   = 40;
	localparam int SQUEEZE_CYCLES = 800;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} vec3_t;

	typedef struct packed {
		logic                       command;
		logic [rsp_pkg::SLOT_W-1:0] slot;
		vec3_t                      pos;
		vec3_t                      dir;
	} ray_word_t;

	typedef struct packed {
		logic                        hit;
		logic [rsp_pkg::INDEX_W-1:0] hit_index;
	} hit_word_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic                           command   = rsp_pkg::CMD_LOAD;
	logic [rsp_pkg::SLOT_W-1:0]     slot      = '0;
	logic [CW-1:0]                  pos_x     = '0;
	logic [CW-1:0]                  pos_y     = '0;
	logic [CW-1:0]                  pos_z     = '0;
	logic [CW-1:0]                  dir_x     = '0;
	logic [CW-1:0]                  dir_y     = '0;
	logic [CW-1:0]                  dir_z     = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           hit;
	logic [rsp_pkg::INDEX_W-1:0]    hit_index;
	logic                           cfg_wr_en = 1'b0;
	logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index = rsp_pkg::REG_STAR_COUNT;
	logic [rsp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	ray_word_t pending_words[$];
	hit_word_t expected_hits[$];
	vec3_t     centres[NUM_SLOTS];  // table as the picker holds it
	vec3_t     drafted[NUM_SLOTS];  // table as queued so far, used for aiming

	logic [rsp_pkg::COUNT_W-1:0]  scan_count = '0;
	logic [rsp_pkg::RADIUS_W-1:0] radius     = rsp_pkg::RADIUS_W'(256);

	int   words_made   = 0;
	int   words_taken  = 0;
	int   results_seen = 0;
	int   mismatches   = 0;
	int   in_gap       = 0;
	int   ready_hold   = 0;
	logic in_fire      = 1'b0;
	bit   idle_off     = 1'b0;
	bit   squeeze_done = 1'b0;

	ray_sphere_first_hit_picker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.slot      (slot),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.hit_index (hit_index),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin : watchdog
		#(400_000_000);
		$display("FAIL");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	function automatic longint sx(logic [CW-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [CW-1:0] sat_coord(longint v);
		longint top;
		top = (longint'(1) <<< (CW - 1)) - 1;
		if (v > top)
			v = top;
		else if (v < -top - 1)
			v = -top - 1;
		return CW'(v);
	endfunction

	function automatic int offset(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// span 0 means the whole coordinate range
	function automatic logic [CW-1:0] rand_coord(int span);
		if (span == 0)
			return CW'($urandom);
		return sat_coord(offset(span));
	endfunction

	// first table entry whose sphere meets the ray line: (d.w)^2 >= (d.d)(w.w - r^2)
	function automatic hit_word_t first_hit_of(ray_word_t w);
		hit_word_t          res;
		longint             wx, wy, wz, dx, dy, dz, dot_dw, dot_dd, cterm, r2;
		logic signed [127:0] lhs, rhs;
		int                 n, i;
		res = '0;
		n = (scan_count > NUM_SLOTS) ? NUM_SLOTS : int'(scan_count);
		dx = sx(w.dir.x);
		dy = sx(w.dir.y);
		dz = sx(w.dir.z);
		dot_dd = dx * dx + dy * dy + dz * dz;
		r2 = longint'(radius) * longint'(radius);
		for (i = 0; i < n && !res.hit; i++) begin
			wx = sx(w.pos.x) - sx(centres[i].x);
			wy = sx(w.pos.y) - sx(centres[i].y);
			wz = sx(w.pos.z) - sx(centres[i].z);
			dot_dw = dx * wx + dy * wy + dz * wz;
			cterm = wx * wx + wy * wy + wz * wz - r2;
			lhs = dot_dw;
			lhs = lhs * lhs;
			rhs = dot_dd;
			rhs = rhs * cterm;
			if (lhs >= rhs) begin
				res.hit = 1'b1;
				res.hit_index = rsp_pkg::INDEX_W'(i);
			end
		end
		return res;
	endfunction

	function automatic ray_word_t mk_word(logic cmd, int s, int px, int py, int pz,
			int dx, int dy, int dz);
		ray_word_t w;
		w.command = cmd;
		w.slot = rsp_pkg::SLOT_W'(s);
		w.pos.x = CW'(px);
		w.pos.y = CW'(py);
		w.pos.z = CW'(pz);
		w.dir.x = CW'(dx);
		w.dir.y = CW'(dy);
		w.dir.z = CW'(dz);
		return w;
	endfunction

	task automatic push_word(ray_word_t w);
		if (w.command == rsp_pkg::CMD_LOAD)
			drafted[w.slot] = w.pos;
		pending_words.push_back(w);
		words_made++;
	endtask

	task automatic push_load(int s, int span);
		ray_word_t w;
		w.command = rsp_pkg::CMD_LOAD;
		w.slot = rsp_pkg::SLOT_W'(s);
		w.pos.x = rand_coord(span);
		w.pos.y = rand_coord(span);
		w.pos.z = rand_coord(span);
		// direction is ignored on a load but still toggles
		w.dir.x = rand_coord(0);
		w.dir.y = rand_coord(0);
		w.dir.z = rand_coord(0);
		push_word(w);
	endtask

	task automatic push_query(int n);
		ray_word_t w;
		vec3_t     c;
		int        k, span, jitter;
		w.command = rsp_pkg::CMD_QUERY;
		w.slot = rsp_pkg::SLOT_W'($urandom);
		if (n > 0 && $urandom_range(0, 1) == 1) begin
			// aim through one loaded centre, exactly or with some noise
			k = $urandom_range(0, n - 1);
			c = drafted[k];
			span = ($urandom_range(0, 2) == 0) ? 256 :
				(($urandom_range(0, 1) == 1) ? 4096 : 16384);
			jitter = ($urandom_range(0, 2) == 0) ? 0 : span / 8;
			w.pos.x = sat_coord(sx(c.x) + offset(span));
			w.pos.y = sat_coord(sx(c.y) + offset(span));
			w.pos.z = sat_coord(sx(c.z) + offset(span));
			w.dir.x = sat_coord(sx(c.x) - sx(w.pos.x) + offset(jitter));
			w.dir.y = sat_coord(sx(c.y) - sx(w.pos.y) + offset(jitter));
			w.dir.z = sat_coord(sx(c.z) - sx(w.pos.z) + offset(jitter));
		end else begin
			span = ($urandom_range(0, 1) == 1) ? 0 : 4096;
			w.pos.x = rand_coord(span);
			w.pos.y = rand_coord(span);
			w.pos.z = rand_coord(span);
			span = ($urandom_range(0, 1) == 1) ? 0 : 512;
			w.dir.x = rand_coord(span);
			w.dir.y = rand_coord(span);
			w.dir.z = rand_coord(span);
			if ($urandom_range(0, 19) == 0)
				w.dir = '0;
		end
		push_word(w);
	endtask

	// picker idle: every word taken, every hit word back, then a further drain wait
	task automatic wait_idle();
		while (words_taken != words_made || expected_hits.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [rsp_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= rsp_pkg::CFG_DATA_W'(val);
		if (idx == rsp_pkg::REG_STAR_COUNT)
			scan_count = rsp_pkg::COUNT_W'(val);
		else
			radius = rsp_pkg::RADIUS_W'(val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// word driver
	always @(negedge clk) begin : word_driver
		ray_word_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				cur = pending_words.pop_front();
				in_valid <= 1'b1;
				command <= cur.command;
				slot <= cur.slot;
				pos_x <= cur.pos.x;
				pos_y <= cur.pos.y;
				pos_z <= cur.pos.z;
				dir_x <= cur.dir.x;
				dir_y <= cur.dir.y;
				dir_z <= cur.dir.z;
				in_gap = idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// hit word receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (!squeeze_done && results_seen >= 150 && pending_words.size() > 4) begin
				// long hold-off: result parks in the output register, input backs up
				ready_hold = SQUEEZE_CYCLES;
				squeeze_done = 1'b1;
			end else if (ready_hold == 0 && $urandom_range(0, 7) == 0) begin
				ready_hold = idle_len();
			end
			if (ready_hold > 0) begin
				ready_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		hit_word_t want;
		ray_word_t taken;
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_hits.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: hit word with nothing outstanding: hit=%0d index=%0d",
						$time, hit, hit_index);
				mismatches++;
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want.hit || hit_index !== want.hit_index) begin
					if (mismatches < 10)
						$display({"%0t: hit word mismatch: expected hit=%0d index=%0d,",
							" got hit=%0d index=%0d"},
							$time, want.hit, want.hit_index, hit, hit_index);
					mismatches++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			words_taken++;
			taken = {command, slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z};
			if (taken.command == rsp_pkg::CMD_LOAD) begin
				if (int'(taken.slot) < NUM_SLOTS)
					centres[taken.slot] = taken.pos;
			end else begin
				expected_hits.push_back(first_hit_of(taken));
			end
		end
	end

	initial begin : stimulus
		int order[NUM_SLOTS];
		int i, j, t, phase, cnt, rad, eff, n_words, sel;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// reset config: nothing scanned, so a miss
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 0, 0, 0, 256, 0, 0));
		push_word(mk_word(rsp_pkg::CMD_LOAD, 0, 32767, 32767, 32767, -1, -1, -1));
		push_word(mk_word(rsp_pkg::CMD_LOAD, 1, -32768, -32768, -32768, 0, 0, 0));
		push_word(mk_word(rsp_pkg::CMD_LOAD, 2, 0, 0, 0, 32767, -32768, 5));
		push_word(mk_word(rsp_pkg::CMD_LOAD, 3, 256, -256, 512, 0, 0, 0));
		push_word(mk_word(rsp_pkg::CMD_LOAD, 255, -32768, 32767, 0, 0, 0, 0));
		wait_idle();

		// zero radius: only lines exactly through a centre count
		write_reg(rsp_pkg::REG_STAR_COUNT, 4);
		write_reg(rsp_pkg::REG_STAR_RADIUS, 0);
		push_word(mk_word(rsp_pkg::CMD_QUERY, 17, 0, 0, 0, 0, 0, 0));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 32767, 32767, 32767, 1, 0, 0));
		// passes through centre 0 with the discriminant exactly zero
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 1, 1));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 0, 0));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 100, 100, 100, 0, 0, 1));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 255, -32768, -32768, -32768,
			-32768, -32768, -32768));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 32767, -32768, 32767,
			32767, -32768, 32767));
		wait_idle();

		write_reg(rsp_pkg::REG_STAR_RADIUS, 32767);
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 256, 0));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 32767, -32768, -32768,
			-32768, 32767, -1));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, -32768, 32767, -32768,
			32767, 32767, 32767));
		push_word(mk_word(rsp_pkg::CMD_LOAD, 0, 0, 0, 0, 1, 2, 3));
		push_word(mk_word(rsp_pkg::CMD_QUERY, 0, 300, -300, 300, 0, 0, -256));
		wait_idle();

		// fill the rest of the table in random order, querying the loaded prefix
		write_reg(rsp_pkg::REG_STAR_RADIUS, 1536);
		for (i = 0; i < NUM_SLOTS - 4; i++)
			order[i] = i + 4;
		for (i = NUM_SLOTS - 5; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (i = 0; i < NUM_SLOTS - 4; i++) begin
			push_load(order[i], ($urandom_range(0, 1) == 1) ? 0 : 4096);
			if ($urandom_range(0, 3) == 0)
				push_query(4);
		end

		phase = 0;
		while (words_made < WORD_TARGET) begin
			wait_idle();
			idle_off = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			rad = (sel == 0) ? 0 :
				(sel == 1) ? 32767 :
				(sel < 6) ? $urandom_range(0, 1024) : $urandom_range(0, 32767);
			case (phase)
				0: begin
					cnt = 256;
					rad = 0;
				end
				1: begin
					// above the table size: scan saturates at the last entry
					cnt = 511;
					rad = $urandom_range(0, 64);
				end
				2: begin
					cnt = 0;
				end
				default: begin
					sel = $urandom_range(0, 99);
					cnt = (sel < 8) ? 0 :
						(sel < 75) ? $urandom_range(1, 8) :
						(sel < 95) ? $urandom_range(9, 32) : $urandom_range(200, 511);
				end
			endcase
			write_reg(rsp_pkg::REG_STAR_COUNT, cnt);
			write_reg(rsp_pkg::REG_STAR_RADIUS, rad);
			eff = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
			// long scans are slow, so those phases stay short
			n_words = (cnt > 64) ? 4 : $urandom_range(20, 60);
			for (i = 0; i < n_words; i++) begin
				if ($urandom_range(0, 2) == 0)
					push_load($urandom_range(0, NUM_SLOTS - 1),
						($urandom_range(0, 1) == 1) ? 0 : 4096);
				else
					push_query(eff);
			end
			phase++;
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
